[rtl/lpfr_pkg.sv]
package lpfr_pkg;

  localparam logic [7:0] HdrFirst   = 8'hAA;
  localparam logic [7:0] HdrSecond  = 8'hAF;
  localparam logic [7:0] FuncBad    = 8'hFF;
  localparam logic [7:0] LimitReset = 8'd50;

  localparam int unsigned ApbAddrW = 2;
  localparam int unsigned ApbDataW = 32;

  typedef struct packed {
    logic       valid;
    logic [7:0] function_code;
    logic [7:0] frame_length;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    logic       last;
    logic       sum_ok;
  } lpfr_result_t;

endpackage

[rtl/lpfr_parse.sv]
module lpfr_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [7:0]            length_limit_i,
  output lpfr_pkg::lpfr_result_t result_o
);
  import lpfr_pkg::*;

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhHdr1 = 3'd1;
  localparam logic [2:0] PhHdr2 = 3'd2;
  localparam logic [2:0] PhFunc = 3'd3;
  localparam logic [2:0] PhData = 3'd4;
  localparam logic [2:0] PhSum  = 3'd5;

  logic [2:0] phase_q, phase_d;
  logic [7:0] func_q, func_d;
  logic [7:0] len_q, len_d;
  logic [7:0] left_q, left_d;
  logic [7:0] seen_q, seen_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] sum_add;

  assign sum_add = sum_q + rx_byte_i;

  always_comb begin
    phase_d = phase_q;
    func_d  = func_q;
    len_d   = len_q;
    left_d  = left_q;
    seen_d  = seen_q;
    sum_d   = sum_q;

    result_o               = '0;
    result_o.function_code = func_q;
    result_o.frame_length  = len_q;
    result_o.data_byte     = rx_byte_i;
    result_o.byte_index    = seen_q;

    phase_d = PhIdle;
    unique case (phase_q)
      PhIdle: begin
        if (rx_byte_i == HdrFirst) begin
          phase_d = PhHdr1;
          sum_d   = rx_byte_i;
        end
      end
      PhHdr1: begin
        if (rx_byte_i == HdrSecond) begin
          phase_d = PhHdr2;
          sum_d   = sum_add;
        end
      end
      PhHdr2: begin
        if (rx_byte_i < FuncBad) begin
          phase_d = PhFunc;
          func_d  = rx_byte_i;
          sum_d   = sum_add;
        end
      end
      PhFunc: begin
        if (rx_byte_i < length_limit_i) begin
          phase_d = PhData;
          len_d   = rx_byte_i;
          left_d  = rx_byte_i;
          seen_d  = '0;
          sum_d   = sum_add;
        end
      end
      PhData: begin
        if (left_q != '0) begin
          left_d         = left_q - 8'd1;
          seen_d         = seen_q + 8'd1;
          sum_d          = sum_add;
          phase_d        = (left_q == 8'd1) ? PhSum : PhData;
          result_o.valid = 1'b1;
        end
      end
      PhSum: begin
        result_o.valid  = 1'b1;
        result_o.last   = 1'b1;
        result_o.sum_ok = (rx_byte_i == sum_q);
      end
      default: phase_d = PhIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      func_q  <= '0;
      len_q   <= '0;
      left_q  <= '0;
      seen_q  <= '0;
      sum_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      func_q  <= func_d;
      len_q   <= len_d;
      left_q  <= left_d;
      seen_q  <= seen_d;
      sum_q   <= sum_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (left_q + seen_q == len_q))
    else $error("Payload counters disagree with the frame length.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhSum) |-> (left_q == '0 && seen_q == len_q))
    else $error("Checksum phase entered with payload outstanding.");

endmodule

[rtl/length_prefixed_frame_receiver_unit.sv]
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_ready_o  rx_byte_i
// out       output     out_valid_o/out_ready_i function_code_o, frame_length_o,
//                                             byte_index_o, data_byte_o, last_o, sum_ok_o
// apb       input      psel/penable/pready   pwrite, paddr, pwdata, prdata
//
// Each byte waits in the input register and is then parsed into the result register;
// only payload and checksum bytes produce a result on the output channel.
// One byte per cycle is sustained while the output is not stalled; the parser state updates once per byte.
// Reset clears the parser to idle and the length limit to 50.
// A stalled output holds the input register, and in_ready_o drops only then.
module length_prefixed_frame_receiver_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     function_code_o,
  output logic [7:0]                     frame_length_o,
  output logic [7:0]                     byte_index_o,
  output logic [7:0]                     data_byte_o,
  output logic                           last_o,
  output logic                           sum_ok_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpfr_pkg::ApbAddrW-1:0]  paddr,
  input  logic [lpfr_pkg::ApbDataW-1:0]  pwdata,
  output logic [lpfr_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import lpfr_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic [7:0]   limit_q;
  logic         out_valid_q;
  lpfr_result_t res_q;
  lpfr_result_t res_d;
  logic         advance;

  assign pready  = 1'b1;
  assign prdata  = (paddr == '0) ? {{(ApbDataW-8){1'b0}}, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (psel && penable && pwrite && pready) begin
      limit_q <= pwdata[7:0];
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  lpfr_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .rx_byte_i      (in_byte_q),
    .length_limit_i (limit_q),
    .result_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_d.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_d.valid) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign function_code_o = res_q.function_code;
  assign frame_length_o  = res_q.frame_length;
  assign byte_index_o    = res_q.byte_index;
  assign data_byte_o     = res_q.data_byte;
  assign last_o          = res_q.last;
  assign sum_ok_o        = res_q.sum_ok;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (byte_index_o == frame_length_o))
    else $error("Checksum transfer index differs from the frame length.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (!sum_ok_o && byte_index_o < frame_length_o))
    else $error("Payload transfer carries a bad index or a sum flag.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_o && !out_ready_i))
    else $error("Input stalled without a blocked output.");

endmodule
